FILE: sv/gpiorb_pkg.sv
// gpiorb_pkg: types, register offsets and codes shared by the GPIO register block.
// No dependencies; used by every module of the block.

package gpiorb_pkg;

  localparam int NUM_PINS_DEFAULT = 54;
  localparam int PIN_SLOTS        = 64;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 32;
  localparam int PAD_W  = 54;
  localparam int FSEL_W = 3;
  localparam int PULL_W = 2;

  localparam int PINS_PER_FSEL  = 10;
  localparam int PINS_PER_DPULL = 16;
  localparam int FSEL_WORDS     = 6;
  localparam int DPULL_WORDS    = 4;

  localparam int S_TDATA_W = 96;
  localparam int M_TDATA_W = 248;

  // word offsets
  localparam logic [ADDR_W-1:0] ADDR_FSEL_LAST = 6'd5;
  localparam logic [ADDR_W-1:0] ADDR_SET0      = 6'd7;
  localparam logic [ADDR_W-1:0] ADDR_SET1      = 6'd8;
  localparam logic [ADDR_W-1:0] ADDR_CLR0      = 6'd10;
  localparam logic [ADDR_W-1:0] ADDR_CLR1      = 6'd11;
  localparam logic [ADDR_W-1:0] ADDR_LEV0      = 6'd13;
  localparam logic [ADDR_W-1:0] ADDR_LEV1      = 6'd14;
  localparam logic [ADDR_W-1:0] ADDR_PULL_CTRL = 6'd37;
  localparam logic [ADDR_W-1:0] ADDR_PULL_CLK0 = 6'd38;
  localparam logic [ADDR_W-1:0] ADDR_PULL_CLK1 = 6'd39;
  localparam logic [ADDR_W-1:0] ADDR_DPULL0    = 6'd57;
  localparam logic [ADDR_W-1:0] ADDR_DPULL3    = 6'd60;

  localparam logic [FSEL_W-1:0] FSEL_OUTPUT = 3'd1;

  // stored pull codes
  localparam logic [PULL_W-1:0] PULL_NONE = 2'd0;
  localparam logic [PULL_W-1:0] PULL_UP   = 2'd1;
  localparam logic [PULL_W-1:0] PULL_DOWN = 2'd2;
  localparam logic [PULL_W-1:0] PULL_RSVD = 2'd3;

  // legacy pull-control encoding
  localparam logic [PULL_W-1:0] LEG_OFF  = 2'd0;
  localparam logic [PULL_W-1:0] LEG_DOWN = 2'd1;
  localparam logic [PULL_W-1:0] LEG_UP   = 2'd2;

  typedef struct packed {
    logic              is_write;
    logic [ADDR_W-1:0] word_addr;
    logic [DATA_W-1:0] write_data;
    logic [PAD_W-1:0]  pad_levels;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [PAD_W-1:0]  output_latch;
    logic [PAD_W-1:0]  output_enable;
    logic [PAD_W-1:0]  pull_up_enable;
    logic [PAD_W-1:0]  pull_down_enable;
  } result_t;

  function automatic logic [PULL_W-1:0] legacy_to_code(input logic [PULL_W-1:0] ctrl);
    logic [PULL_W-1:0] code;
    case (ctrl)
      LEG_OFF:  code = PULL_NONE;
      LEG_DOWN: code = PULL_DOWN;
      LEG_UP:   code = PULL_UP;
      default:  code = PULL_RSVD;
    endcase
    return code;
  endfunction

endpackage

FILE: sv/gpiorb_in_stage.sv
// gpiorb_in_stage: input register for bus access items.
// Depends on gpiorb_pkg (item_t).

module gpiorb_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gpiorb_pkg::item_t in_item,
  input  logic              advance,
  output logic              fire,
  output gpiorb_pkg::item_t item
);

  logic held;
  logic held_next;
  logic accept;

  assign fire     = held && advance;
  assign in_ready = !held || advance;
  assign accept   = in_valid && in_ready;
  assign held_next = accept || (held && !advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

endmodule

FILE: sv/gpiorb_regfile.sv
// gpiorb_regfile: GPIO register state, address decode, read mux and pin controls.
// Depends on gpiorb_pkg (item_t, result_t, offsets, pull codes).

module gpiorb_regfile #(
  parameter int NUM_PINS = gpiorb_pkg::NUM_PINS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                direct_pull_mode,
  input  logic                fire,
  input  gpiorb_pkg::item_t   item,
  output gpiorb_pkg::result_t result
);

  localparam int SLOTS  = gpiorb_pkg::PIN_SLOTS;
  localparam int DW     = gpiorb_pkg::DATA_W;
  localparam int PW     = gpiorb_pkg::PAD_W;
  localparam int FW     = gpiorb_pkg::FSEL_W;
  localparam int UW     = gpiorb_pkg::PULL_W;
  localparam logic [PW-1:0] PAD_MASK =
    (NUM_PINS >= PW) ? {PW{1'b1}} : PW'((64'd1 << NUM_PINS) - 64'd1);

  logic [gpiorb_pkg::ADDR_W-1:0] a;
  logic [gpiorb_pkg::ADDR_W-1:0] dpull_off;
  logic wr;
  logic sel_fsel, sel_set, sel_clr, sel_lev, sel_pctl, sel_pclk, sel_dpull;
  logic set_hi, clr_hi, lev_hi, pclk_hi;

  logic [UW-1:0] pull_ctrl, pull_ctrl_next;
  logic [DW-1:0] pull_clk0, pull_clk0_next;
  logic [DW-1:0] pull_clk1, pull_clk1_next;

  logic [FW-1:0] fsel_now  [SLOTS];
  logic [FW-1:0] fsel_next [SLOTS];
  logic [UW-1:0] pull_now  [SLOTS];
  logic [UW-1:0] pull_next [SLOTS];
  logic [SLOTS-1:0] lat_next;
  logic [SLOTS-1:0] oe_all, pu_all, pd_all;

  logic [DW-1:0] fsel_words  [gpiorb_pkg::FSEL_WORDS];
  logic [DW-1:0] dpull_words [gpiorb_pkg::DPULL_WORDS];
  logic [63:0]   pads_ext;
  logic [DW-1:0] rd;

  assign a  = item.word_addr;
  assign wr = fire && item.is_write;

  assign sel_fsel  = (a <= gpiorb_pkg::ADDR_FSEL_LAST);
  assign sel_set   = (a == gpiorb_pkg::ADDR_SET0) || (a == gpiorb_pkg::ADDR_SET1);
  assign set_hi    = (a == gpiorb_pkg::ADDR_SET1);
  assign sel_clr   = (a == gpiorb_pkg::ADDR_CLR0) || (a == gpiorb_pkg::ADDR_CLR1);
  assign clr_hi    = (a == gpiorb_pkg::ADDR_CLR1);
  assign sel_lev   = (a == gpiorb_pkg::ADDR_LEV0) || (a == gpiorb_pkg::ADDR_LEV1);
  assign lev_hi    = (a == gpiorb_pkg::ADDR_LEV1);
  assign sel_pctl  = !direct_pull_mode && (a == gpiorb_pkg::ADDR_PULL_CTRL);
  assign sel_pclk  = !direct_pull_mode &&
                     ((a == gpiorb_pkg::ADDR_PULL_CLK0) || (a == gpiorb_pkg::ADDR_PULL_CLK1));
  assign pclk_hi   = (a == gpiorb_pkg::ADDR_PULL_CLK1);
  assign sel_dpull = direct_pull_mode &&
                     (a >= gpiorb_pkg::ADDR_DPULL0) && (a <= gpiorb_pkg::ADDR_DPULL3);
  assign dpull_off = a - gpiorb_pkg::ADDR_DPULL0;

  assign pull_ctrl_next = (wr && sel_pctl) ? item.write_data[UW-1:0] : pull_ctrl;
  assign pull_clk0_next = (wr && sel_pclk && !pclk_hi) ? item.write_data : pull_clk0;
  assign pull_clk1_next = (wr && sel_pclk &&  pclk_hi) ? item.write_data : pull_clk1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pull_ctrl <= '0;
      pull_clk0 <= '0;
      pull_clk1 <= '0;
    end else begin
      pull_ctrl <= pull_ctrl_next;
      pull_clk0 <= pull_clk0_next;
      pull_clk1 <= pull_clk1_next;
    end
  end

  for (genvar p = 0; p < SLOTS; p++) begin : g_pin
    if (p < NUM_PINS) begin : g_used
      localparam int FWORD = p / gpiorb_pkg::PINS_PER_FSEL;
      localparam int FK    = p % gpiorb_pkg::PINS_PER_FSEL;
      localparam int HW    = p / gpiorb_pkg::DATA_W;
      localparam int HB    = p % gpiorb_pkg::DATA_W;
      localparam int DWORD = p / gpiorb_pkg::PINS_PER_DPULL;
      localparam int DK    = p % gpiorb_pkg::PINS_PER_DPULL;
      localparam logic [gpiorb_pkg::ADDR_W-1:0] FWORD_A = gpiorb_pkg::ADDR_W'(FWORD);
      localparam logic [1:0] DWORD_A = 2'(DWORD);
      localparam logic       HW_B    = 1'(HW);

      logic [FW-1:0] fsel;
      logic [UW-1:0] pull;
      logic          lat;
      logic          lat_set, lat_clr, clk_was, clk_rise, direct_hit;

      assign lat_set  = wr && sel_set && (set_hi == HW_B) && item.write_data[HB];
      assign lat_clr  = wr && sel_clr && (clr_hi == HW_B) && item.write_data[HB];
      assign clk_was  = HW_B ? pull_clk1[HB] : pull_clk0[HB];
      // legacy pull latches only on a 0 to 1 edge of this pin's clock bit
      assign clk_rise = wr && sel_pclk && (pclk_hi == HW_B) && item.write_data[HB] && !clk_was;
      assign direct_hit = wr && sel_dpull && (dpull_off[1:0] == DWORD_A);

      assign fsel_next[p] = (wr && sel_fsel && (a == FWORD_A)) ?
                            item.write_data[FK*FW +: FW] : fsel;
      assign pull_next[p] = direct_hit ? item.write_data[DK*UW +: UW] :
                            clk_rise   ? gpiorb_pkg::legacy_to_code(pull_ctrl) : pull;
      assign lat_next[p]  = (lat || lat_set) && !lat_clr;
      assign fsel_now[p]  = fsel;
      assign pull_now[p]  = pull;

      always_ff @(posedge clk) begin
        if (rst) begin
          fsel <= '0;
          pull <= '0;
          lat  <= 1'b0;
        end else begin
          fsel <= fsel_next[p];
          pull <= pull_next[p];
          lat  <= lat_next[p];
        end
      end
    end else begin : g_absent
      assign fsel_next[p] = '0;
      assign pull_next[p] = '0;
      assign lat_next[p]  = 1'b0;
      assign fsel_now[p]  = '0;
      assign pull_now[p]  = '0;
    end

    assign oe_all[p] = (fsel_next[p] == gpiorb_pkg::FSEL_OUTPUT);
    assign pu_all[p] = (pull_next[p] == gpiorb_pkg::PULL_UP);
    assign pd_all[p] = (pull_next[p] == gpiorb_pkg::PULL_DOWN);
  end

  always_comb begin
    for (int w = 0; w < gpiorb_pkg::FSEL_WORDS; w++) begin
      fsel_words[w] = '0;
      for (int k = 0; k < gpiorb_pkg::PINS_PER_FSEL; k++) begin
        fsel_words[w][k*FW +: FW] = fsel_now[w*gpiorb_pkg::PINS_PER_FSEL + k];
      end
    end
    for (int w = 0; w < gpiorb_pkg::DPULL_WORDS; w++) begin
      for (int k = 0; k < gpiorb_pkg::PINS_PER_DPULL; k++) begin
        dpull_words[w][k*UW +: UW] = pull_now[w*gpiorb_pkg::PINS_PER_DPULL + k];
      end
    end
  end

  assign pads_ext = 64'(item.pad_levels & PAD_MASK);

  // reads see the state before the access; writes return zero
  always_comb begin
    rd = '0;
    if (!item.is_write) begin
      if (sel_fsel) begin
        rd = fsel_words[a[2:0]];
      end else if (sel_lev) begin
        rd = lev_hi ? pads_ext[63:32] : pads_ext[31:0];
      end else if (sel_pctl) begin
        rd = DW'(pull_ctrl);
      end else if (sel_pclk) begin
        rd = pclk_hi ? pull_clk1 : pull_clk0;
      end else if (sel_dpull) begin
        rd = dpull_words[dpull_off[1:0]];
      end
    end
  end

  assign result.read_data        = rd;
  assign result.output_latch     = lat_next[PW-1:0];
  assign result.output_enable    = oe_all[PW-1:0];
  assign result.pull_up_enable   = pu_all[PW-1:0];
  assign result.pull_down_enable = pd_all[PW-1:0];

endmodule

FILE: sv/gpiorb_out_stage.sv
// gpiorb_out_stage: result register holding one item until the sink takes it.
// Depends on gpiorb_pkg (result_t).

module gpiorb_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  gpiorb_pkg::result_t load_result,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_ready,
  output gpiorb_pkg::result_t result
);

  logic full;
  logic full_next;

  // a waiting result leaves in the same cycle a new one arrives
  assign advance   = !full || out_ready;
  assign full_next = load || (full && !out_ready);
  assign out_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_result;
    end
  end

endmodule

FILE: sv/gpio_register_block.sv
// gpio_register_block: top level of the GPIO register block.
// Depends on gpiorb_pkg, gpiorb_in_stage, gpiorb_regfile and gpiorb_out_stage.

// One 32-bit register access per item, one item per clock sustained while
// the sink keeps taking results. An item goes through the input register,
// is decoded and applied to the register state in one read-modify-write
// pass, and its result is loaded into the output register when that register
// is free or being emptied; otherwise the input register holds the item. The
// result carries the read word (zero for writes) and the pin controls as they
// stand after the access. The user is to write direct_pull_mode through the
// cfg channel between accesses; the block itself leaves this unenforced.

module gpio_register_block #(
  parameter int NUM_PINS = gpiorb_pkg::NUM_PINS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // word_addr[5:0], write_data[37:6], pad_levels[91:38], zero fill [95:92]
  input  logic [gpiorb_pkg::S_TDATA_W-1:0] s_tdata,
  // is_write[0]
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // read_data[31:0], output_latch[85:32], output_enable[139:86],
  // pull_up_enable[193:140], pull_down_enable[247:194]
  output logic [gpiorb_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_data
);

  localparam int AW = gpiorb_pkg::ADDR_W;
  localparam int DW = gpiorb_pkg::DATA_W;
  localparam int PW = gpiorb_pkg::PAD_W;

  logic direct_pull_mode;
  logic direct_pull_mode_next;
  logic fire;
  logic advance;

  gpiorb_pkg::item_t   in_item;
  gpiorb_pkg::item_t   item;
  gpiorb_pkg::result_t core_result;
  gpiorb_pkg::result_t out_result;

  assign cfg_ready = 1'b1;
  assign direct_pull_mode_next = (cfg_valid && cfg_ready) ? cfg_data : direct_pull_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      direct_pull_mode <= 1'b0;
    end else begin
      direct_pull_mode <= direct_pull_mode_next;
    end
  end

  assign in_item.is_write   = s_tuser;
  assign in_item.word_addr  = s_tdata[AW-1:0];
  assign in_item.write_data = s_tdata[AW+DW-1:AW];
  assign in_item.pad_levels = s_tdata[AW+DW+PW-1:AW+DW];

  gpiorb_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .advance  (advance),
    .fire     (fire),
    .item     (item)
  );

  gpiorb_regfile #(
    .NUM_PINS (NUM_PINS)
  ) u_regs (
    .clk              (clk),
    .rst              (rst),
    .direct_pull_mode (direct_pull_mode),
    .fire             (fire),
    .item             (item),
    .result           (core_result)
  );

  gpiorb_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (fire),
    .load_result (core_result),
    .advance     (advance),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .result      (out_result)
  );

  assign m_tdata = {out_result.pull_down_enable, out_result.pull_up_enable,
                    out_result.output_enable, out_result.output_latch,
                    out_result.read_data};

endmodule

FILE: bench/gpio_checker.sv
// gpio_checker: watches the access, result and cfg channels of gpio_register_block,
// predicts each result from its own copy of the register state and compares field by field.
// Depends on gpiorb_pkg for widths, offsets and codes.

module gpio_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [gpiorb_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                             s_tuser,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [gpiorb_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic                             cfg_data,
  output int                               mismatches,
  output int                               pending
);
  import gpiorb_pkg::*;

  localparam int NPINS = NUM_PINS_DEFAULT;

  logic [FSEL_W-1:0] fsel     [NPINS];
  logic [PULL_W-1:0] pin_pull [NPINS];
  logic [PAD_W-1:0]  latch;
  logic [PULL_W-1:0] pull_ctl;
  logic [31:0]       pull_clk [2];
  logic              direct_mode;

  result_t expected_results[$];
  int      results_seen;

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    $display("ERROR: result %0d %s: got %h, wanted %h", results_seen, field, got, want);
    mismatches++;
  endtask

  // Applies one bus access to the shadow state, returns the result it should give.
  function automatic result_t apply_access(input item_t acc);
    result_t           r;
    int                a;
    int                p;
    int                w;
    logic [63:0]       wide;
    logic [31:0]       rise;
    logic [PULL_W-1:0] code;
    r = '0;
    a = acc.word_addr;
    if (acc.is_write) begin
      if (a <= ADDR_FSEL_LAST) begin
        for (int k = 0; k < PINS_PER_FSEL; k++) begin
          p = a * PINS_PER_FSEL + k;
          if (p < NPINS) fsel[p] = acc.write_data[3*k +: 3];
        end
      end else if (a == ADDR_SET0 || a == ADDR_SET1) begin
        wide = 64'(acc.write_data) << (32 * (a - ADDR_SET0));
        latch |= wide[PAD_W-1:0];
      end else if (a == ADDR_CLR0 || a == ADDR_CLR1) begin
        wide = 64'(acc.write_data) << (32 * (a - ADDR_CLR0));
        latch &= ~wide[PAD_W-1:0];
      end else if (!direct_mode && a == ADDR_PULL_CTRL) begin
        pull_ctl = acc.write_data[1:0];
      end else if (!direct_mode && (a == ADDR_PULL_CLK0 || a == ADDR_PULL_CLK1)) begin
        w = a - ADDR_PULL_CLK0;
        rise = acc.write_data & ~pull_clk[w];
        // legacy control encoding differs from the stored code
        case (pull_ctl)
          LEG_OFF:  code = PULL_NONE;
          LEG_DOWN: code = PULL_DOWN;
          LEG_UP:   code = PULL_UP;
          default:  code = PULL_RSVD;
        endcase
        for (int k = 0; k < 32; k++) begin
          p = w * 32 + k;
          if (rise[k] && p < NPINS) pin_pull[p] = code;
        end
        pull_clk[w] = acc.write_data;
      end else if (direct_mode && a >= ADDR_DPULL0 && a <= ADDR_DPULL3) begin
        for (int k = 0; k < PINS_PER_DPULL; k++) begin
          p = (a - ADDR_DPULL0) * PINS_PER_DPULL + k;
          if (p < NPINS) pin_pull[p] = acc.write_data[2*k +: 2];
        end
      end
    end else begin
      if (a <= ADDR_FSEL_LAST) begin
        for (int k = 0; k < PINS_PER_FSEL; k++) begin
          p = a * PINS_PER_FSEL + k;
          if (p < NPINS) r.read_data[3*k +: 3] = fsel[p];
        end
      end else if (a == ADDR_LEV0 || a == ADDR_LEV1) begin
        wide = 64'(acc.pad_levels);
        r.read_data = wide[32*(a - ADDR_LEV0) +: 32];
      end else if (!direct_mode && a == ADDR_PULL_CTRL) begin
        r.read_data = 32'(pull_ctl);
      end else if (!direct_mode && (a == ADDR_PULL_CLK0 || a == ADDR_PULL_CLK1)) begin
        r.read_data = pull_clk[a - ADDR_PULL_CLK0];
      end else if (direct_mode && a >= ADDR_DPULL0 && a <= ADDR_DPULL3) begin
        for (int k = 0; k < PINS_PER_DPULL; k++) begin
          p = (a - ADDR_DPULL0) * PINS_PER_DPULL + k;
          if (p < NPINS) r.read_data[2*k +: 2] = pin_pull[p];
        end
      end
    end
    for (int q = 0; q < NPINS; q++) begin
      r.output_enable[q]    = (fsel[q] == FSEL_OUTPUT);
      r.pull_up_enable[q]   = (pin_pull[q] == PULL_UP);
      r.pull_down_enable[q] = (pin_pull[q] == PULL_DOWN);
    end
    r.output_latch = latch;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    item_t   acc;
    if (rst) begin
      for (int q = 0; q < NPINS; q++) begin
        fsel[q]     = '0;
        pin_pull[q] = PULL_NONE;
      end
      latch       = '0;
      pull_ctl    = '0;
      pull_clk[0] = '0;
      pull_clk[1] = '0;
      direct_mode = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) direct_mode = cfg_data;
      if (m_tvalid && m_tready) begin
        got.read_data        = m_tdata[31:0];
        got.output_latch     = m_tdata[85:32];
        got.output_enable    = m_tdata[139:86];
        got.pull_up_enable   = m_tdata[193:140];
        got.pull_down_enable = m_tdata[247:194];
        if (expected_results.size() == 0) begin
          report("unexpected result", 64'(got.read_data), '0);
        end else begin
          want = expected_results.pop_front();
          if (got.read_data !== want.read_data)
            report("read_data", 64'(got.read_data), 64'(want.read_data));
          if (got.output_latch !== want.output_latch)
            report("output_latch", 64'(got.output_latch), 64'(want.output_latch));
          if (got.output_enable !== want.output_enable)
            report("output_enable", 64'(got.output_enable), 64'(want.output_enable));
          if (got.pull_up_enable !== want.pull_up_enable)
            report("pull_up_enable", 64'(got.pull_up_enable), 64'(want.pull_up_enable));
          if (got.pull_down_enable !== want.pull_down_enable)
            report("pull_down_enable", 64'(got.pull_down_enable),
                   64'(want.pull_down_enable));
        end
        results_seen++;
      end
      if (s_tvalid && s_tready) begin
        acc.is_write   = s_tuser;
        acc.word_addr  = s_tdata[5:0];
        acc.write_data = s_tdata[37:6];
        acc.pad_levels = s_tdata[91:38];
        expected_results.push_back(apply_access(acc));
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: bench/tb_top.sv
// tb_top: stimulus and verdict for gpio_register_block; directed accesses, then random
// ones under three idling regimes with pull-mode changes in between.
// Depends on gpiorb_pkg, gpio_register_block and gpio_checker.

module tb_top;
  import gpiorb_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_FSEL0        = 6'd0;
  localparam logic [ADDR_W-1:0] ADDR_UNMAPPED_TOP = 6'd63;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic                 s_tuser   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_data  = 1'b0;

  int   mismatches;
  int   pending;
  int   snd_idle_pct  = 0;
  int   rcv_idle_pct  = 0;
  int   accesses_sent = 0;
  logic cur_mode      = 1'b0;
  logic stall_request = 1'b0;
  logic stall_taken   = 1'b0;
  int   stall_left    = 0;

  gpio_register_block dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  gpio_checker chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_request && !stall_taken) begin
      stall_taken <= 1'b1;
      stall_left  <= 80;
      m_tready    <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic send_access(input logic wr, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data, input logic [PAD_W-1:0] pads);
    if ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= wr;
    s_tdata  <= {4'b0, pads, data, addr};
    do @(posedge clk); while (!s_tready);
    accesses_sent++;
  endtask

  // sender pause until every result is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pull_mode(input logic mode);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_mode = mode;
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    case ($urandom_range(7))
      0:       return ADDR_W'($urandom_range(63));
      1, 2:    return ADDR_W'($urandom_range(ADDR_FSEL_LAST));
      3: begin
        case ($urandom_range(3))
          0:       return ADDR_SET0;
          1:       return ADDR_SET1;
          2:       return ADDR_CLR0;
          default: return ADDR_CLR1;
        endcase
      end
      4:       return $urandom_range(1) ? ADDR_LEV1 : ADDR_LEV0;
      5:       return ADDR_W'(ADDR_PULL_CTRL + $urandom_range(2));
      default: return ADDR_W'(ADDR_DPULL0 + $urandom_range(3));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(5))
      0:       return '1;
      1:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PAD_W-1:0] pick_pads();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? '1 : '0;
    return PAD_W'({$urandom, $urandom});
  endfunction

  // A well-formed pull sequence for the current mode, or a single random access.
  task automatic random_access();
    logic [ADDR_W-1:0] a;
    int                w;
    if ($urandom_range(99) < 25) begin
      if (!cur_mode) begin
        w = $urandom_range(1);
        a = ADDR_W'(ADDR_PULL_CLK0 + w);
        send_access(1'b1, ADDR_PULL_CTRL,
                    $urandom_range(3) == 0 ? pick_word() : DATA_W'($urandom_range(3)),
                    pick_pads());
        send_access(1'b1, a, pick_word(), pick_pads());
        send_access(1'b0, $urandom_range(1) ? a : ADDR_PULL_CTRL, pick_word(), pick_pads());
        if ($urandom_range(1)) send_access(1'b1, a, '0, pick_pads());
      end else begin
        a = ADDR_W'(ADDR_DPULL0 + $urandom_range(3));
        send_access(1'b1, a, pick_word(), pick_pads());
        send_access(1'b0, a, pick_word(), pick_pads());
      end
    end else begin
      send_access(1'(($urandom_range(1))), pick_addr(), pick_word(), pick_pads());
    end
  endtask

  initial begin
    int target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_pull_mode(1'b0);

    // function select: unused top bits, pins past the last one
    send_access(1'b1, ADDR_FSEL0, 32'hffff_ffff, '0);
    send_access(1'b0, ADDR_FSEL0, 32'h0, '1);
    send_access(1'b1, ADDR_FSEL_LAST, 32'h3fff_ffff, '0);
    send_access(1'b0, ADDR_FSEL_LAST, 32'h0, '0);
    // set and clear, both halves; set words read as zero
    send_access(1'b1, ADDR_SET0, 32'hffff_ffff, '0);
    send_access(1'b1, ADDR_SET1, 32'hffff_ffff, '0);
    send_access(1'b0, ADDR_SET0, 32'h0, '0);
    send_access(1'b1, ADDR_CLR1, 32'hffff_ffff, '0);
    send_access(1'b1, ADDR_CLR0, 32'h5555_5555, '0);
    // pad levels; a write to a level word is dropped
    send_access(1'b0, ADDR_LEV0, 32'h0, '1);
    send_access(1'b0, ADDR_LEV1, 32'h0, '1);
    send_access(1'b1, ADDR_LEV1, 32'hffff_ffff, '0);
    send_access(1'b0, ADDR_LEV0, 32'h0, '0);
    // legacy pulls: only rising clock bits latch, a reserved control code is stored and read back
    send_access(1'b1, ADDR_PULL_CTRL, 32'(LEG_UP), '0);
    send_access(1'b1, ADDR_PULL_CLK0, 32'hffff_ffff, '0);
    send_access(1'b1, ADDR_PULL_CTRL, 32'(LEG_DOWN), '0);
    send_access(1'b1, ADDR_PULL_CLK0, 32'hffff_ffff, '0);
    send_access(1'b1, ADDR_PULL_CLK1, 32'hffff_ffff, '0);
    send_access(1'b1, ADDR_PULL_CTRL, 32'hffff_ffff, '0);
    send_access(1'b0, ADDR_PULL_CTRL, 32'h0, '0);
    send_access(1'b1, ADDR_PULL_CLK0, 32'h0000_0001, '0);
    // direct pull words are unmapped in legacy mode; so is the top word
    send_access(1'b1, ADDR_DPULL3, 32'hffff_ffff, '0);
    send_access(1'b0, ADDR_DPULL3, 32'h0, '0);
    send_access(1'b1, ADDR_UNMAPPED_TOP, 32'hffff_ffff, '0);
    send_access(1'b0, ADDR_UNMAPPED_TOP, 32'h0, '1);

    set_pull_mode(1'b1);
    send_access(1'b1, ADDR_DPULL0, 32'hffff_ffff, '0);
    send_access(1'b1, ADDR_DPULL3, 32'haaaa_aaaa, '0);
    send_access(1'b0, ADDR_DPULL3, 32'h0, '0);
    send_access(1'b1, ADDR_PULL_CTRL, 32'(LEG_UP), '0);
    send_access(1'b0, ADDR_PULL_CLK0, 32'h0, '0);

    for (int seg = 0; seg < 6; seg++) begin
      set_pull_mode(seg % 2 == 1);
      case (seg / 2)
        0: begin
          snd_idle_pct = 7;
          rcv_idle_pct = 87;
        end
        1: begin
          snd_idle_pct = 87;
          rcv_idle_pct = 7;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      // last segment: long hold-off on results while items keep coming
      if (seg == 5) stall_request <= 1'b1;
      target = accesses_sent + 115;
      while (accesses_sent < target) begin
        random_access();
        if (seg == 5 && accesses_sent >= target - 57 && accesses_sent < target - 52)
          wait_drained();
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: gpio_register_block.f
sv/gpiorb_pkg.sv
sv/gpiorb_in_stage.sv
sv/gpiorb_regfile.sv
sv/gpiorb_out_stage.sv
sv/gpio_register_block.sv
bench/gpio_checker.sv
bench/tb_top.sv
